// File: hw/rtl/tts_pkg.sv
// shared types and constants of the tick task scheduler
`timescale 1ns / 1ps

package tts_pkg;

  localparam int NUM_SLOTS_DEF = 8;
  localparam int OP_W          = 2;
  localparam int IVL_W         = 16;
  localparam int RDY_W         = 8;
  localparam int STATUS_W      = 2;
  localparam int SLOT_FIELD_W  = 3;

  localparam logic [RDY_W-1:0] RDY_MAX = {RDY_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_TICK         = 2'd0,
    OP_ADD_PERIODIC = 2'd1,
    OP_ADD_ONESHOT  = 2'd2,
    OP_DISPATCH     = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_TICK     = 2'd0,
    ST_ADDED    = 2'd1,
    ST_FULL     = 2'd2,
    ST_DISPATCH = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  // one slot of the task table
  typedef struct packed {
    logic             periodic;
    logic [IVL_W-1:0] interval;
    logic [IVL_W-1:0] countdown;
    logic [RDY_W-1:0] ready_cnt;
  } slot_entry_t;

  // what the update unit hands back for the slot under work
  typedef struct packed {
    slot_entry_t tick_entry;
    slot_entry_t disp_entry;
    logic        has_ready;
  } slot_upd_t;

  typedef struct packed {
    status_t                 status;
    logic [SLOT_FIELD_W-1:0] slot;
    logic                    dispatched;
  } result_t;

endpackage

// File: hw/rtl/tts_channels.sv
// valid/ready channel interfaces for items in and results out
`timescale 1ns / 1ps

interface tts_in_if import tts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [IVL_W-1:0] interval;

  modport source (output valid, output operation, output interval, input ready);
  modport sink (input valid, input operation, input interval, output ready);
endinterface

interface tts_out_if import tts_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [SLOT_FIELD_W-1:0] slot;
  logic                    dispatched;

  modport source (output valid, output status, output slot, output dispatched, input ready);
  modport sink (input valid, input status, input slot, input dispatched, output ready);
endinterface

// File: hw/rtl/tts_slot_mem.sv
// task table memory, one write and one registered read per cycle
`timescale 1ns / 1ps

module tts_slot_mem import tts_pkg::*; #(
  parameter int DEPTH = NUM_SLOTS_DEF,
  parameter int IDX_W = 3
) (
  input  logic              clk,
  input  logic              we,
  input  logic [IDX_W-1:0]  waddr,
  input  slot_entry_t       wdata,
  input  logic [IDX_W-1:0]  raddr,
  output slot_entry_t       rdata
);

  slot_entry_t mem [DEPTH];
  slot_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/tts_slot_alu.sv
// shared slot update unit: tick countdown step and dispatch decrement
`timescale 1ns / 1ps

module tts_slot_alu import tts_pkg::*; (
  input  slot_entry_t cur,
  output slot_upd_t   upd
);

  logic [IVL_W-1:0] cd_dec;
  logic             cd_hits_zero;
  slot_entry_t      tick_e;
  slot_entry_t      disp_e;

  assign cd_dec       = cur.countdown - IVL_W'(1);
  assign cd_hits_zero = (cd_dec == '0);

  always_comb begin
    tick_e = cur;
    if (cur.periodic) begin
      tick_e.countdown = cd_dec;
      if (cd_hits_zero) begin
        tick_e.countdown = cur.interval;
        if (cur.ready_cnt != RDY_MAX) begin
          tick_e.ready_cnt = cur.ready_cnt + RDY_W'(1);
        end
      end
    end else if (cur.countdown != '0) begin
      tick_e.countdown = cd_dec;
      if (cd_hits_zero) begin
        tick_e.ready_cnt = RDY_W'(1);
      end
    end
  end

  always_comb begin
    disp_e           = cur;
    disp_e.ready_cnt = cur.ready_cnt - RDY_W'(1);
  end

  assign upd.tick_entry = tick_e;
  assign upd.disp_entry = disp_e;
  assign upd.has_ready  = (cur.ready_cnt != '0);

endmodule

// File: hw/rtl/tick_task_scheduler_unit.sv
// top level of the tick task scheduler: sequencer, fill count and result register
`timescale 1ns / 1ps

// Cooperative tick scheduler with a table of NUM_SLOTS task slots held in a
// single-port-write, registered-read memory. Add items fill slots in order and
// pass through an accept step and a result step. Tick and dispatch items walk
// the filled slots one per cycle through one shared update unit, reading slot
// k+1 while slot k is worked on: a tick visits every filled slot, a dispatch
// stops early at the first slot with work ready. With an empty table tick and
// dispatch items go straight from accept to result. One item is worked on at a
// time; the next item is taken as soon as the result has moved to the output
// register, even if it has not been collected yet. Slot numbers on the result
// carry the low 3 bits of the index.

module tick_task_scheduler_unit import tts_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  tts_in_if.sink        in_ch,
  tts_out_if.source     out_ch
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  // sequencer state
  state_t           state_r, state_nxt;
  op_t              op_r, op_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  result_t          res_r, res_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  result_t          out_res_r, out_res_nxt;

  // memory port
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  slot_entry_t      mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  slot_entry_t      mem_rdata;

  slot_upd_t        upd;

  op_t              in_op;
  logic             walk_last;
  logic             table_full;
  logic             out_free;
  logic [IDX_W+SLOT_FIELD_W-1:0] idx_ext;
  logic [IDX_W+SLOT_FIELD_W-1:0] add_ext;

  assign in_op      = op_t'(in_ch.operation);
  assign walk_last  = ((CNT_W'(idx_r) + CNT_W'(1)) == used_r);
  assign table_full = (used_r == CNT_W'(NUM_SLOTS));
  assign out_free   = !out_valid_r || out_ch.ready;

  // slot numbers are reported by their low bits
  assign idx_ext = {{SLOT_FIELD_W{1'b0}}, idx_r};
  assign add_ext = {{SLOT_FIELD_W{1'b0}}, used_r[IDX_W-1:0]};

  tts_slot_mem #(
    .DEPTH (NUM_SLOTS),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tts_slot_alu u_alu (
    .cur (mem_rdata),
    .upd (upd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and walk bookkeeping need no reset
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    idx_r     <= idx_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    used_nxt      = used_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = upd.tick_entry;
    mem_raddr     = '0;
    in_ch.ready   = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        // ready is high here, so valid alone marks an accepted item
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          op_nxt  = in_op;
          idx_nxt = '0;
          unique case (in_op)
            OP_TICK, OP_DISPATCH: begin
              // start the walk at slot 0; the read data shows up next cycle
              if (used_r == '0) begin
                res_nxt.status     = (in_op == OP_TICK) ? ST_TICK : ST_DISPATCH;
                res_nxt.slot       = '0;
                res_nxt.dispatched = 1'b0;
                state_nxt          = S_DONE;
              end else begin
                state_nxt = S_WALK;
              end
            end
            OP_ADD_PERIODIC, OP_ADD_ONESHOT: begin
              res_nxt.dispatched = 1'b0;
              if (table_full) begin
                res_nxt.status = ST_FULL;
                res_nxt.slot   = '0;
              end else begin
                mem_we                = 1'b1;
                mem_waddr             = used_r[IDX_W-1:0];
                mem_wdata.periodic    = (in_op == OP_ADD_PERIODIC);
                mem_wdata.interval    = (in_op == OP_ADD_PERIODIC) ? in_ch.interval : '0;
                mem_wdata.countdown   = in_ch.interval;
                mem_wdata.ready_cnt   = '0;
                used_nxt              = used_r + CNT_W'(1);
                res_nxt.status        = ST_ADDED;
                res_nxt.slot          = add_ext[SLOT_FIELD_W-1:0];
              end
              state_nxt = S_DONE;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_WALK: begin
        // read ahead one slot while the current one is worked on
        mem_raddr          = idx_r + IDX_W'(1);
        res_nxt.dispatched = 1'b0;
        res_nxt.slot       = '0;
        if (op_r == OP_TICK) begin
          mem_we         = 1'b1;
          mem_wdata      = upd.tick_entry;
          res_nxt.status = ST_TICK;
          if (walk_last) begin
            state_nxt = S_DONE;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end else begin
          res_nxt.status = ST_DISPATCH;
          priority if (upd.has_ready) begin
            mem_we             = 1'b1;
            mem_wdata          = upd.disp_entry;
            res_nxt.slot       = idx_ext[SLOT_FIELD_W-1:0];
            res_nxt.dispatched = 1'b1;
            state_nxt          = S_DONE;
          end else if (walk_last) begin
            state_nxt = S_DONE;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end

      S_DONE: begin
        // hand over once the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_res_r.status;
  assign out_ch.slot       = out_res_r.slot;
  assign out_ch.dispatched = out_res_r.dispatched;

endmodule

// File: hw/rtl/tts_checker.sv
// port-level checks of the tick task scheduler, bound to the top level
`timescale 1ns / 1ps

module tts_checker import tts_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [STATUS_W-1:0]     out_status,
  input logic [SLOT_FIELD_W-1:0] out_slot,
  input logic                    out_dispatched
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_r, pend_nxt;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // items taken whose result has not been collected
  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 2'd1;
    end else if (!in_acc && out_acc) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_slot)
      && $stable(out_dispatched))
    else $error("result changed while stalled");

  a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> (pend_r != 2'd0) || in_acc)
    else $error("result without a pending item");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("more than two items outstanding");

  a_disp_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dispatched |-> status_t'(out_status) == ST_DISPATCH)
    else $error("dispatch flag on a non-dispatch result");

  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status_t'(out_status) == ST_TICK || status_t'(out_status) == ST_FULL
      || (status_t'(out_status) == ST_DISPATCH && !out_dispatched)) |-> out_slot == '0)
    else $error("slot set on a result without a slot");

endmodule

bind tick_task_scheduler_unit tts_checker u_tts_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_slot       (out_ch.slot),
  .out_dispatched (out_ch.dispatched)
);
